FILE: rtl/core/key_matrix_and_encoder_scanner_core_macros.svh
// Assertion helpers shared by the scanner RTL.
`ifndef KEY_MATRIX_AND_ENCODER_SCANNER_CORE_MACROS_SVH
`define KEY_MATRIX_AND_ENCODER_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, checked outside reset.
`define KMES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

FILE: rtl/core/kmes_pkg.sv
package kmes_pkg;

  localparam int unsigned HistoryDepthDef = 4;
  localparam int unsigned NumRows         = 7;
  localparam int unsigned NumBanks        = 3;

  localparam int unsigned StepW  = 5;
  localparam int unsigned RowW   = 3;
  localparam int unsigned BankW  = 2;
  localparam int unsigned LineW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [StepW-1:0] LastStep = 5'd27;
  localparam logic [RowW-1:0]  LastRow  = 3'd6;
  localparam logic [LineW-1:0] LineEncBank0 = 4'd7;
  localparam logic [LineW-1:0] LineEncBank1 = 4'd8;
  localparam logic [LineW-1:0] LineEncBank2 = 4'd9;

  localparam logic [ByteW-1:0] HalfMask0Rst = 8'hFF;
  localparam logic [ByteW-1:0] HalfMask1Rst = 8'h30;
  localparam logic [ByteW-1:0] HalfMask2Rst = 8'hFC;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHalfMask0 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfMask1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfMask2 = 2'd2;

  // Write request into one history lane.
  typedef struct packed {
    logic            en;
    logic [RowW-1:0] row;
  } hist_req_t;

  // Request into the shared quadrature decoder.
  typedef struct packed {
    logic             en;
    logic [BankW-1:0] bank;
    logic [ByteW-1:0] half_mask;
  } dec_req_t;

endpackage

FILE: rtl/core/kmes_hist_lane.sv
module kmes_hist_lane
  import kmes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hist_req_t        req_i,
  input  logic [ByteW-1:0] even_i,
  input  logic [ByteW-1:0] odd_i,
  output logic [ByteW-1:0] even_o,
  output logic [ByteW-1:0] odd_o
);

  // One history slot for every row: even byte in the low half, odd in the high half.
  logic [2*ByteW-1:0] slot_q [NumRows];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        slot_q[r] <= '0;
      end
    end else if (req_i.en) begin
      slot_q[req_i.row] <= {odd_i, even_i};
    end
  end

  // A lane being written this cycle shows the new sample.
  always_comb begin
    if (req_i.en) begin
      even_o = even_i;
      odd_o  = odd_i;
    end else begin
      even_o = slot_q[req_i.row][ByteW-1:0];
      odd_o  = slot_q[req_i.row][2*ByteW-1:ByteW];
    end
  end

endmodule

FILE: rtl/core/kmes_quad_dec.sv
module kmes_quad_dec
  import kmes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dec_req_t         req_i,
  input  logic [ByteW-1:0] a_i,
  input  logic [ByteW-1:0] b_i,
  output logic [ByteW-1:0] cw_tog_o,
  output logic [ByteW-1:0] ccw_tog_o,
  output logic [ByteW-1:0] rot_o
);

  logic [ByteW-1:0] phase_q   [NumBanks];
  logic [ByteW-1:0] prev_a_q  [NumBanks];
  logic [ByteW-1:0] prev_b_q  [NumBanks];
  logic [ByteW-1:0] cw_arm_q  [NumBanks];
  logic [ByteW-1:0] ccw_arm_q [NumBanks];
  logic [ByteW-1:0] cw_tog_q  [NumBanks];
  logic [ByteW-1:0] ccw_tog_q [NumBanks];

  logic [ByteW-1:0] s, ap, bp, cwa, ccwa;
  logic [ByteW-1:0] half, dir, hcw, hccw, acw, accw;
  logic [ByteW-1:0] phase_d, cw_arm_d, ccw_arm_d, cw_tog_d, ccw_tog_d;

  // All eight decoders of a bank run bitwise in parallel.
  always_comb begin
    s    = phase_q[req_i.bank];
    ap   = prev_a_q[req_i.bank];
    bp   = prev_b_q[req_i.bank];
    cwa  = cw_arm_q[req_i.bank];
    ccwa = ccw_arm_q[req_i.bank];
    // A half step needs the previous phases to differ and now agree.
    half = ~(a_i ^ b_i) & (a_i ^ s) & (ap ^ bp);
    dir  = s ^ bp;
    hcw  = half & dir;
    hccw = half & ~dir;
    // A full step ends a same-direction half-step pair, or is any half step with its mask bit set.
    acw  = (hcw & cwa) | (hcw & req_i.half_mask);
    accw = (hccw & ccwa) | (hccw & req_i.half_mask);
    phase_d   = (a_i & b_i) | (s & (a_i ^ b_i));
    cw_arm_d  = (cwa & ~half) | (hcw & ~cwa);
    ccw_arm_d = (ccwa & ~half) | (hccw & ~ccwa);
    cw_tog_d  = cw_tog_q[req_i.bank] ^ acw;
    ccw_tog_d = ccw_tog_q[req_i.bank] ^ accw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumBanks; k++) begin
        phase_q[k]   <= '0;
        prev_a_q[k]  <= '0;
        prev_b_q[k]  <= '0;
        cw_arm_q[k]  <= '0;
        ccw_arm_q[k] <= '0;
        cw_tog_q[k]  <= '0;
        ccw_tog_q[k] <= '0;
      end
    end else if (req_i.en) begin
      phase_q[req_i.bank]   <= phase_d;
      prev_a_q[req_i.bank]  <= a_i;
      prev_b_q[req_i.bank]  <= b_i;
      cw_arm_q[req_i.bank]  <= cw_arm_d;
      ccw_arm_q[req_i.bank] <= ccw_arm_d;
      cw_tog_q[req_i.bank]  <= cw_tog_d;
      ccw_tog_q[req_i.bank] <= ccw_tog_d;
    end
  end

  assign cw_tog_o  = cw_tog_d;
  assign ccw_tog_o = ccw_tog_d;
  assign rot_o     = acw | accw;

endmodule

FILE: rtl/core/key_matrix_and_encoder_scanner_core.sv
// Key matrix and rotary encoder scanner.
// Each input transaction is one scan tick: the two active-low column ports
// sampled while the previously announced line was enabled. A fixed 28-step
// schedule interleaves seven button rows with three encoder banks.
// Every input transaction produces exactly one output transaction carrying
// the step number, the debounced buttons or encoder toggle bytes, the
// encoders that rotated, and the line to enable for the next tick.
// The result is registered at the edge that accepts the input. Throughput is
// one transaction per cycle while the receiver takes each result; the history
// lanes and the decoder all finish their update at that same edge.
// The half-step masks are written on the cfg port and take effect on the
// next encoder step of their bank.
// Reset clears the history store, all decoder state and the output valid flag,
// and restores the mask defaults; the first tick is step 0 (row 0).
// When the receiver stalls, the held result stays on the outputs and input
// is accepted again in the same cycle that the result is taken.
`include "key_matrix_and_encoder_scanner_core_macros.svh"

module key_matrix_and_encoder_scanner_core
  import kmes_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   col_even_i,
  input  logic [ByteW-1:0]   col_odd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StepW-1:0]   step_done_o,
  output logic               is_encoder_o,
  output logic [RowW-1:0]    unit_index_o,
  output logic [ByteW-1:0]   first_byte_o,
  output logic [ByteW-1:0]   second_byte_o,
  output logic [ByteW-1:0]   rotated_bits_o,
  output logic [LineW-1:0]   next_line_o
);

  localparam int unsigned HidxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [HidxW-1:0] HidxLast = HidxW'(HISTORY_DEPTH - 1);

  // Configuration registers.
  logic [ByteW-1:0] half_mask_q [NumBanks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_mask_q[0] <= HalfMask0Rst;
      half_mask_q[1] <= HalfMask1Rst;
      half_mask_q[2] <= HalfMask2Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfMask0: half_mask_q[0] <= cfg_wdata_i;
        CfgHalfMask1: half_mask_q[1] <= cfg_wdata_i;
        CfgHalfMask2: half_mask_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the output register decouples the two sides.
  logic out_valid_q;
  logic in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Schedule position of the tick being accepted.
  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       phase;
  logic [RowW-1:0]  row;
  logic             row_step;
  logic [BankW-1:0] bank;

  assign step_d   = (step_q == LastStep) ? '0 : step_q + StepW'(1);
  assign phase    = step_d[1:0];
  assign row      = step_d[StepW-1:2];
  assign row_step = (phase == 2'd0);
  assign bank     = phase - 2'd1;

  // History index advances on row 0, before that row is stored.
  logic [HidxW-1:0] hidx_q, hidx_d;

  always_comb begin
    hidx_d = hidx_q;
    if (row_step && (row == '0)) begin
      hidx_d = (hidx_q == HidxLast) ? '0 : hidx_q + HidxW'(1);
    end
  end

  logic [ByteW-1:0] a, b;
  assign a = ~col_even_i;
  assign b = ~col_odd_i;

  // History lanes: lane l keeps history slot l of every row.
  logic [ByteW-1:0] lane_even [HISTORY_DEPTH];
  logic [ByteW-1:0] lane_odd  [HISTORY_DEPTH];

  for (genvar l = 0; l < HISTORY_DEPTH; l++) begin : g_lane
    hist_req_t lane_req;
    assign lane_req.en  = in_acc && row_step && (hidx_d == HidxW'(l));
    assign lane_req.row = row;

    kmes_hist_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (lane_req),
      .even_i (a),
      .odd_i  (b),
      .even_o (lane_even[l]),
      .odd_o  (lane_odd[l])
    );
  end

  // Merge: a button counts as pressed only if every slot saw it pressed.
  logic [ByteW-1:0] deb_even, deb_odd;

  always_comb begin
    deb_even = '1;
    deb_odd  = '1;
    for (int l = 0; l < HISTORY_DEPTH; l++) begin
      deb_even &= lane_even[l];
      deb_odd  &= lane_odd[l];
    end
  end

  // Shared quadrature decoder; banks take turns on their schedule steps.
  dec_req_t         dec_req;
  logic [ByteW-1:0] cw_tog, ccw_tog, rot;

  assign dec_req.en        = in_acc && !row_step;
  assign dec_req.bank      = bank;
  assign dec_req.half_mask = half_mask_q[bank];

  kmes_quad_dec u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dec_req),
    .a_i       (a),
    .b_i       (b),
    .cw_tog_o  (cw_tog),
    .ccw_tog_o (ccw_tog),
    .rot_o     (rot)
  );

  // Line to enable after this step.
  logic [LineW-1:0] next_line;

  always_comb begin
    unique case (phase)
      2'd0: next_line = LineEncBank0;
      2'd1: next_line = LineEncBank1;
      2'd2: next_line = LineEncBank2;
      default: next_line = (row == LastRow) ? '0 : LineW'(row) + LineW'(1);
    endcase
  end

  // Result register.
  logic [StepW-1:0] step_done_q;
  logic             is_enc_q;
  logic [RowW-1:0]  unit_q;
  logic [ByteW-1:0] first_q, second_q, rot_q;
  logic [LineW-1:0] next_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= LastStep;
      hidx_q      <= '0;
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
        step_q      <= step_d;
        hidx_q      <= hidx_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      step_done_q <= step_d;
      is_enc_q    <= !row_step;
      unit_q      <= row_step ? row : RowW'(bank);
      first_q     <= row_step ? deb_even : cw_tog;
      second_q    <= row_step ? deb_odd : ccw_tog;
      rot_q       <= row_step ? '0 : rot;
      next_line_q <= next_line;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign step_done_o    = step_done_q;
  assign is_encoder_o   = is_enc_q;
  assign unit_index_o   = unit_q;
  assign first_byte_o   = first_q;
  assign second_byte_o  = second_q;
  assign rotated_bits_o = rot_q;
  assign next_line_o    = next_line_q;

  `KMES_ASSERT_NXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_q)
  `KMES_ASSERT_NXT(a_wrap_to_zero, clk_i, rst_ni, in_acc && (step_q == LastStep), step_q == '0)
  `KMES_ASSERT_NOW(a_row_no_rot, clk_i, rst_ni, out_valid_q && !is_enc_q, rot_q == '0)
  `KMES_ASSERT_NOW(a_row_next_enc, clk_i, rst_ni, out_valid_q && !is_enc_q, next_line_q == LineEncBank0)
  `KMES_ASSERT_NOW(a_hidx_range, clk_i, rst_ni, 1'b1, hidx_q <= HidxLast)

endmodule
